// File: design/sgr_pkg.sv
// Package for the stream group reverser: payload types, sizing constants,
// drain state codes and group size clamp. No dependencies.
package sgr_pkg;

	localparam int MAX_GROUP = 16;
	localparam int VAL_W     = 32;
	localparam int CFG_W     = 5;
	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic                    list_last;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic                    run_end;
		logic                    list_end;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} drain_state_t;

	// zero means one, anything above the buffer depth saturates
	function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] raw);
		logic [CMP_W-1:0] k;
		k = CMP_W'(raw);
		if (k == '0) begin
			k = CMP_W'(1);
		end
		if (k > CMP_W'(MAX_GROUP)) begin
			k = CMP_W'(MAX_GROUP);
		end
		return k[CNT_W-1:0];
	endfunction

endpackage

// File: design/stream_group_reverser_unit.sv
// Top level of the stream group reverser: group size register, clamp, group
// buffer RAM and drain control. Depends on sgr_pkg, sgr_ram, sgr_ctrl.
//
//  channel   dir  handshake             payload
//  item      in   item_valid/stall      in_item_t  {item_value, list_last}
//  result    out  result_valid/stall    out_item_t {out_value, run_end, list_end}
//  cfg       in   cfg_valid/ready       group_size, 5 bits
//
// An item that completes no run is only written to the buffer. An item that ends a group of n
// values (or ends the list with n held) starts a drain of n reads from the single read
// port, each read's data passing through the RAM read register to the output register;
// the unit then returns to idle and takes the next item.
// Reset: group size 1, fill count 0; buffer content is not cleared.
// A stall on result only pauses the drain; nothing is lost.
module stream_group_reverser_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  sgr_pkg::in_item_t         item_data,
	output logic                      result_valid,
	input  logic                      result_stall,
	output sgr_pkg::out_item_t        result_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sgr_pkg::CFG_W-1:0] cfg_data
);

	logic [sgr_pkg::CFG_W-1:0] group_size_q;
	logic [sgr_pkg::CNT_W-1:0] group_k;
	sgr_pkg::ram_req_t         ram_req;
	logic [sgr_pkg::VAL_W-1:0] ram_rdata;

	// the register request is always taken and lands at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= sgr_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			group_size_q <= cfg_data;
		end
	end

	// effective size: zero acts as one, saturates at buffer depth
	assign group_k = sgr_pkg::clamp_size(group_size_q);

	sgr_ram #(
		.DEPTH(sgr_pkg::MAX_GROUP),
		.WIDTH(sgr_pkg::VAL_W)
	) u_buf (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	sgr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.group_k      (group_k),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata)
	);

endmodule

// File: design/sgr_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module sgr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/sgr_ctrl.sv
// Fill and drain control for the group reverser: fill count, drain sequencer,
// read pipeline and output register. Depends on sgr_pkg.
module sgr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sgr_pkg::CNT_W-1:0]  group_k,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  sgr_pkg::in_item_t          item_data,
	output logic                       result_valid,
	input  logic                       result_stall,
	output sgr_pkg::out_item_t         result_data,
	output sgr_pkg::ram_req_t          ram_req,
	input  logic [sgr_pkg::VAL_W-1:0]  ram_rdata
);

	sgr_pkg::drain_state_t state_q, state_d;

	logic [sgr_pkg::CNT_W-1:0] fill_q;
	logic [sgr_pkg::CNT_W-1:0] left_q;
	logic [sgr_pkg::IDX_W-1:0] idx_q;
	logic                      rev_q;
	logic                      last_q;
	logic                      rd_s1;
	logic                      run_s1;
	logic                      lend_s1;
	logic                      result_valid_q;
	sgr_pkg::out_item_t        result_q;

	logic                      accept;
	logic [sgr_pkg::CNT_W-1:0] n_new;
	logic                      trig_rev;
	logic                      trig_fwd;
	logic                      issue;
	logic                      move;

	assign accept   = item_valid && !item_stall;
	assign n_new    = fill_q + sgr_pkg::CNT_W'(1);
	assign trig_rev = n_new >= group_k;
	assign trig_fwd = item_data.list_last && !trig_rev;
	assign move     = rd_s1 && (!result_valid_q || !result_stall);
	assign issue    = (state_q == sgr_pkg::ST_DRAIN) && (left_q != '0) && (!rd_s1 || move);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgr_pkg::ST_IDLE: begin
				if (accept && (trig_rev || trig_fwd)) begin
					state_d = sgr_pkg::ST_DRAIN;
				end
			end
			sgr_pkg::ST_DRAIN: begin
				if ((left_q == '0) && !rd_s1) begin
					state_d = sgr_pkg::ST_IDLE;
				end
			end
			default: state_d = sgr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall    = 1'b1;
		ram_req.we    = 1'b0;
		ram_req.waddr = fill_q[sgr_pkg::IDX_W-1:0];
		ram_req.wdata = item_data.item_value;
		ram_req.re    = issue;
		ram_req.raddr = idx_q;
		unique case (state_q)
			sgr_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				ram_req.we = item_valid;
			end
			sgr_pkg::ST_DRAIN: begin
				item_stall = 1'b1;
			end
			default: item_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgr_pkg::ST_IDLE;
			fill_q  <= '0;
			left_q  <= '0;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fill_q <= (trig_rev || trig_fwd) ? '0 : n_new;
				left_q <= (trig_rev || trig_fwd) ? n_new : '0;
			end else if (issue) begin
				left_q <= left_q - sgr_pkg::CNT_W'(1);
			end
			if (issue) begin
				rd_s1 <= 1'b1;
			end else if (move) begin
				rd_s1 <= 1'b0;
			end
		end
	end

	// drain pointer and per-run flags
	always_ff @(posedge clk) begin
		if (accept) begin
			rev_q  <= trig_rev;
			last_q <= item_data.list_last;
			idx_q  <= trig_rev ? fill_q[sgr_pkg::IDX_W-1:0] : '0;
		end else if (issue) begin
			idx_q <= rev_q ? (idx_q - sgr_pkg::IDX_W'(1)) : (idx_q + sgr_pkg::IDX_W'(1));
		end
		if (issue) begin
			run_s1  <= (left_q == sgr_pkg::CNT_W'(1));
			lend_s1 <= (left_q == sgr_pkg::CNT_W'(1)) && last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			result_q.out_value <= ram_rdata;
			result_q.run_end   <= run_s1;
			result_q.list_end  <= lend_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !trig_rev && !trig_fwd |=> (state_q == sgr_pkg::ST_IDLE)
			&& (fill_q == sgr_pkg::CNT_W'($past(fill_q) + sgr_pkg::CNT_W'(1))))
		else $error("fill count did not advance on a held value");

	a_drain_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (trig_rev || trig_fwd) |=> (state_q == sgr_pkg::ST_DRAIN)
			&& (left_q == sgr_pkg::CNT_W'($past(fill_q) + sgr_pkg::CNT_W'(1))) && (fill_q == '0))
		else $error("drain length does not match held count");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 && result_valid_q && result_stall |=> rd_s1)
		else $error("pending read data dropped under stall");

	a_list_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.list_end |-> result_q.run_end)
		else $error("list end without run end");

endmodule
